// ----- rtl/core/fwkv_pkg.sv -----
// fwkv_pkg: shared types and constants of the write-back key/value cache.
// No dependencies; imported by every module of the block except fwkv_ram.
package fwkv_pkg;

   localparam int CAP_BITS  = 5;
   localparam int CAP_RESET = 16;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_GET   = 2'd1,
      OP_FILL  = 2'd2,
      OP_FLUSH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      KIND_REPLY = 2'd0,
      KIND_WB    = 2'd1,
      KIND_READ  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_EVICT,
      ST_FLUSH,
      ST_FLWB,
      ST_REPLY
   } state_type;

   // head of the request queue as seen by the back end
   typedef struct packed {
      logic   valid;
      op_type op;
      logic   found;
   } head_type;

endpackage

// ----- rtl/core/fwkv_ram.sv -----
// fwkv_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fwkv_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- rtl/core/fwkv_front.sv -----
// fwkv_front: request intake; a two-entry queue that decodes the op field.
// Depends on fwkv_pkg.
module fwkv_front
   import fwkv_pkg::*;
#(
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_found,
   input  logic                  pop,
   output head_type              head,
   output logic [KEY_BITS-1:0]   head_key,
   output logic [VALUE_BITS-1:0] head_value
);
   op_type                op_ff    [2];
   logic                  found_ff [2];
   logic [KEY_BITS-1:0]   key_ff   [2];
   logic [VALUE_BITS-1:0] value_ff [2];
   logic                  wptr_ff, wptr_in;
   logic                  rptr_ff, rptr_in;
   logic [1:0]            count_ff, count_in;
   logic                  push;

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;

   always_comb begin
      wptr_in  = wptr_ff ^ push;
      rptr_in  = rptr_ff ^ pop;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         op_ff[wptr_ff]    <= op_type'(req_op);
         found_ff[wptr_ff] <= req_found;
         key_ff[wptr_ff]   <= req_key;
         value_ff[wptr_ff] <= req_value;
      end
   end

   always_comb begin
      head.valid = (count_ff != 2'd0);
      head.op    = op_ff[rptr_ff];
      head.found = found_ff[rptr_ff];
   end
   assign head_key   = key_ff[rptr_ff];
   assign head_value = value_ff[rptr_ff];
endmodule

// ----- rtl/core/fwkv_back.sv -----
// fwkv_back: tag store, ring pointers, sequencer and result register.
// Depends on fwkv_pkg and fwkv_ram (value store).
module fwkv_back
   import fwkv_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CAP_BITS-1:0]   csr_capacity,
   input  head_type              head,
   input  logic [KEY_BITS-1:0]   head_key,
   input  logic [VALUE_BITS-1:0] head_value,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [KEY_BITS-1:0]   rsp_key_res,
   output logic [VALUE_BITS-1:0] rsp_value_res,
   output logic                  rsp_status,
   output logic                  rsp_last
);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [CAP_BITS-1:0]   cap_ff;
   logic [DEPTH-1:0]      valid_ff, dirty_ff;
   logic [KEY_BITS-1:0]   keys_ff [DEPTH];
   logic [IW-1:0]         oldest_ff, next_ff, ptr_ff, ptr_in;
   logic [CW-1:0]         count_ff, walk_ff, walk_in;
   state_type             state_ff, state_in;
   op_type                op_ff;
   logic                  found_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic                  hit_ff, hit_in;

   logic                  rsp_valid_ff;
   kind_type              rsp_kind_ff;
   logic [KEY_BITS-1:0]   rsp_key_ff;
   logic [VALUE_BITS-1:0] rsp_value_ff;
   logic                  rsp_status_ff, rsp_last_ff;

   logic [CW-1:0]         ecap;
   logic                  hit;
   logic [IW-1:0]         hidx;
   logic                  can_emit, emit, e_status, e_last;
   kind_type              e_kind;
   logic [KEY_BITS-1:0]   e_key;
   logic [VALUE_BITS-1:0] e_value;
   logic                  we, re;
   logic [IW-1:0]         waddr, raddr;
   logic                  upd_hit, do_insert, do_evict, clr_dirty;
   logic                  new_dirty;
   logic [VALUE_BITS-1:0] rdata;

   function automatic logic [IW-1:0] ring_inc(logic [IW-1:0] x, logic [CW-1:0] c);
      if ((CW+1)'(x) + (CW+1)'(1) >= (CW+1)'(c)) begin
         return '0;
      end
      return x + IW'(1);
   endfunction

   always_comb begin
      if (int'(cap_ff) > DEPTH) begin
         ecap = CW'(DEPTH);
      end else begin
         ecap = CW'(cap_ff);
      end
   end

   // parallel tag compare; keys are unique among valid entries
   always_comb begin
      hit  = 1'b0;
      hidx = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (valid_ff[i] && keys_ff[i] == key_ff) begin
            hit  = 1'b1;
            hidx = IW'(i);
         end
      end
   end

   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign new_dirty = (op_ff == OP_SET);

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      hit_in    = hit_ff;
      ptr_in    = ptr_ff;
      walk_in   = walk_ff;
      emit      = 1'b0;
      e_kind    = KIND_WB;
      e_key     = key_ff;
      e_value   = value_ff;
      e_status  = 1'b0;
      e_last    = 1'b0;
      we        = 1'b0;
      waddr     = next_ff;
      re        = 1'b0;
      raddr     = oldest_ff;
      upd_hit   = 1'b0;
      do_insert = 1'b0;
      do_evict  = 1'b0;
      clr_dirty = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            hit_in = hit;
            case (op_ff)
               OP_SET, OP_FILL: begin
                  if (op_ff == OP_FILL && (!found_ff || ecap == '0)) begin
                     state_in = ST_REPLY;
                  end else if (ecap == '0) begin
                     // bypass: post the write straight to the backing store
                     if (can_emit) begin
                        emit     = 1'b1;
                        state_in = ST_REPLY;
                     end
                  end else if (hit) begin
                     we       = 1'b1;
                     waddr    = hidx;
                     upd_hit  = 1'b1;
                     state_in = ST_REPLY;
                  end else if (count_ff >= ecap) begin
                     re       = 1'b1;
                     state_in = ST_EVICT;
                  end else begin
                     we        = 1'b1;
                     do_insert = 1'b1;
                     state_in  = ST_REPLY;
                  end
               end
               OP_GET: begin
                  re       = hit;
                  raddr    = hidx;
                  state_in = ST_REPLY;
               end
               default: begin
                  ptr_in   = oldest_ff;
                  walk_in  = '0;
                  state_in = ST_FLUSH;
               end
            endcase
         end
         ST_EVICT: begin
            e_key   = keys_ff[oldest_ff];
            e_value = rdata;
            if (!(valid_ff[oldest_ff] && dirty_ff[oldest_ff]) || can_emit) begin
               emit      = valid_ff[oldest_ff] && dirty_ff[oldest_ff];
               we        = 1'b1;
               do_evict  = 1'b1;
               do_insert = 1'b1;
               state_in  = ST_REPLY;
            end
         end
         ST_FLUSH: begin
            if (walk_ff == ecap) begin
               state_in = ST_REPLY;
            end else if (valid_ff[ptr_ff] && dirty_ff[ptr_ff]) begin
               re       = 1'b1;
               raddr    = ptr_ff;
               state_in = ST_FLWB;
            end else begin
               ptr_in  = ring_inc(ptr_ff, ecap);
               walk_in = walk_ff + CW'(1);
            end
         end
         ST_FLWB: begin
            e_key   = keys_ff[ptr_ff];
            e_value = rdata;
            if (can_emit) begin
               emit      = 1'b1;
               clr_dirty = 1'b1;
               ptr_in    = ring_inc(ptr_ff, ecap);
               walk_in   = walk_ff + CW'(1);
               state_in  = ST_FLUSH;
            end
         end
         ST_REPLY: begin
            e_kind  = KIND_REPLY;
            e_last  = 1'b1;
            e_value = '0;
            case (op_ff)
               OP_GET: begin
                  if (hit_ff) begin
                     e_value = rdata;
                  end else begin
                     e_kind = KIND_READ;
                  end
               end
               OP_FILL: begin
                  e_status = !found_ff;
                  if (found_ff) begin
                     e_value = value_ff;
                  end
               end
               OP_FLUSH: begin
                  e_key = '0;
               end
               default: begin
               end
            endcase
            if (can_emit) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_BITS'(CAP_RESET);
         valid_ff     <= '0;
         dirty_ff     <= '0;
         oldest_ff    <= '0;
         next_ff      <= '0;
         count_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            // a capacity write empties the cache; dirty data is dropped
            cap_ff    <= csr_capacity;
            valid_ff  <= '0;
            dirty_ff  <= '0;
            oldest_ff <= '0;
            next_ff   <= '0;
            count_ff  <= '0;
         end else begin
            if (upd_hit) begin
               dirty_ff[hidx] <= new_dirty;
            end
            if (clr_dirty) begin
               dirty_ff[ptr_ff] <= 1'b0;
            end
            // a full ring has next == oldest, so the insert below reuses the evicted slot
            if (do_evict) begin
               oldest_ff <= ring_inc(oldest_ff, ecap);
            end
            if (do_insert) begin
               valid_ff[next_ff] <= 1'b1;
               dirty_ff[next_ff] <= new_dirty;
               next_ff           <= ring_inc(next_ff, ecap);
               if (!do_evict) begin
                  count_ff <= count_ff + CW'(1);
               end
            end
         end
      end
      if (do_insert) begin
         keys_ff[next_ff] <= key_ff;
      end
      if (pop) begin
         op_ff    <= head.op;
         found_ff <= head.found;
         key_ff   <= head_key;
         value_ff <= head_value;
      end
      hit_ff  <= hit_in;
      ptr_ff  <= ptr_in;
      walk_ff <= walk_in;
      if (emit) begin
         rsp_kind_ff   <= e_kind;
         rsp_key_ff    <= e_key;
         rsp_value_ff  <= e_value;
         rsp_status_ff <= e_status;
         rsp_last_ff   <= e_last;
      end
   end

   fwkv_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_values (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (value_ff),
      .re    (re),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_key_res   = rsp_key_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;
endmodule

// ----- rtl/core/fifo_writeback_kv_cache.sv -----
// Write-back key/value cache, FIFO replacement, DEPTH entries, in front of a backing
// store. A two-entry request queue feeds a sequencer that takes one item at a time.
// Sets and gets pass the decide and reply states, a set that evicts also an evict
// state; a flush walks the value RAM from the oldest entry by its single read port.
// Results leave through a register, so a stalled output blocks the sequencer, and
// request intake once the queue is full. Capacity writes are taken at once.
// Depends on fwkv_pkg, fwkv_front, fwkv_back, fwkv_ram.
module fifo_writeback_kv_cache
   import fwkv_pkg::*;
#(
   parameter int DEPTH      = 16,
   parameter int KEY_BITS   = 32,
   parameter int VALUE_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CAP_BITS-1:0]   csr_capacity,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_op,
   input  logic [KEY_BITS-1:0]   req_key,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_found,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [KEY_BITS-1:0]   rsp_key_res,
   output logic [VALUE_BITS-1:0] rsp_value_res,
   output logic                  rsp_status,
   output logic                  rsp_last
);
   head_type              head;
   logic [KEY_BITS-1:0]   head_key;
   logic [VALUE_BITS-1:0] head_value;
   logic                  pop;

   assign csr_ready = 1'b1;

   fwkv_front #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_op     (req_op),
      .req_key    (req_key),
      .req_value  (req_value),
      .req_found  (req_found),
      .pop        (pop),
      .head       (head),
      .head_key   (head_key),
      .head_value (head_value)
   );

   fwkv_back #(
      .DEPTH      (DEPTH),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .csr_write     (csr_valid && csr_ready),
      .csr_capacity  (csr_capacity),
      .head          (head),
      .head_key      (head_key),
      .head_value    (head_value),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_kind      (rsp_kind),
      .rsp_key_res   (rsp_key_res),
      .rsp_value_res (rsp_value_res),
      .rsp_status    (rsp_status),
      .rsp_last      (rsp_last)
   );

`ifndef SYNTHESIS
   a_read_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_READ |-> rsp_last)
      else $error("read request not last item");
   a_wb_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_WB |-> !rsp_last)
      else $error("write-back marked last");
   a_status_reply: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_kind == KIND_REPLY && rsp_value_res == '0)
      else $error("not-found status on wrong item");
`endif
endmodule

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for the write-back key/value cache.
// A cache model in the bench predicts every result, and a checker process compares them.
// Depends on fwkv_pkg and fifo_writeback_kv_cache.
module tb_top;
   import fwkv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int LIMIT_CYCLES = 600000;

   typedef struct {
      kind_type    kind;
      logic [31:0] key;
      logic [63:0] value;
      logic        status;
      logic        last;
   } result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CAP_BITS-1:0] csr_capacity = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_op = '0;
   logic [31:0] req_key = '0;
   logic [63:0] req_value = '0;
   logic req_found = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [31:0] rsp_key_res;
   logic [63:0] rsp_value_res;
   logic rsp_status;
   logic rsp_last;

   fifo_writeback_kv_cache #(.DEPTH(DEPTH), .KEY_BITS(32), .VALUE_BITS(64)) u_top (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_capacity(csr_capacity),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op), .req_key(req_key),
      .req_value(req_value), .req_found(req_found),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_kind(rsp_kind),
      .rsp_key_res(rsp_key_res), .rsp_value_res(rsp_value_res),
      .rsp_status(rsp_status), .rsp_last(rsp_last));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // cache model
   logic [31:0] tag_mem [DEPTH];
   logic [63:0] word_mem [DEPTH];
   logic        live [DEPTH];
   logic        dirty [DEPTH];
   int unsigned head_slot, tail_slot, fill_count, capacity;

   result_type pending_results[$];
   int errors = 0;
   int cycles = 0;
   int burst_left = 0;
   int hold_req = 0;
   logic [31:0] key_pool[24];
   logic [31:0] missed_keys[$];

   function automatic int unsigned live_cap();
      return capacity > DEPTH ? DEPTH : capacity;
   endfunction

   function automatic void empty_cache();
      for (int i = 0; i < DEPTH; i++) begin
         live[i] = 1'b0;
         dirty[i] = 1'b0;
      end
      head_slot = 0;
      tail_slot = 0;
      fill_count = 0;
   endfunction

   function automatic int find_slot(logic [31:0] key);
      for (int i = 0; i < live_cap(); i++)
         if (live[i] && tag_mem[i] == key) return i;
      return -1;
   endfunction

   function automatic void push_result(kind_type kind, logic [31:0] key, logic [63:0] value,
                                       logic status);
      result_type r;
      r.kind = kind;
      r.key = key;
      r.value = value;
      r.status = status;
      r.last = 1'b0;
      pending_results.push_back(r);
   endfunction

   function automatic void cache_insert(logic [31:0] key, logic [63:0] value, logic mark);
      int unsigned c, s;
      int hit;
      c = live_cap();
      hit = find_slot(key);
      if (hit >= 0) begin
         word_mem[hit] = value;
         dirty[hit] = mark;
         return;
      end
      if (c == 0) return;
      if (fill_count >= c) begin
         s = head_slot % c;
         if (live[s] && dirty[s]) push_result(KIND_WB, tag_mem[s], word_mem[s], 1'b0);
         live[s] = 1'b0;
         dirty[s] = 1'b0;
         head_slot = (s + 1) % c;
         fill_count--;
      end
      s = tail_slot % c;
      tag_mem[s] = key;
      word_mem[s] = value;
      live[s] = 1'b1;
      dirty[s] = mark;
      tail_slot = (s + 1) % c;
      fill_count++;
   endfunction

   function automatic void predict_item(op_type op, logic [31:0] key, logic [63:0] value,
                                        logic found);
      int unsigned c, s;
      int hit;
      c = live_cap();
      case (op)
         OP_SET: begin
            if (c == 0) push_result(KIND_WB, key, value, 1'b0);
            else cache_insert(key, value, 1'b1);
            push_result(KIND_REPLY, key, '0, 1'b0);
         end
         OP_GET: begin
            hit = (c == 0) ? -1 : find_slot(key);
            if (hit >= 0) push_result(KIND_REPLY, key, word_mem[hit], 1'b0);
            else begin
               push_result(KIND_READ, key, '0, 1'b0);
               missed_keys.push_back(key);
            end
         end
         OP_FILL: begin
            if (!found) push_result(KIND_REPLY, key, '0, 1'b1);
            else begin
               if (c != 0) cache_insert(key, value, 1'b0);
               push_result(KIND_REPLY, key, value, 1'b0);
            end
         end
         default: begin
            for (int i = 0; i < c; i++) begin
               s = (head_slot + i) % c;
               if (live[s] && dirty[s]) begin
                  push_result(KIND_WB, tag_mem[s], word_mem[s], 1'b0);
                  dirty[s] = 1'b0;
               end
            end
            push_result(KIND_REPLY, '0, '0, 1'b0);
         end
      endcase
      pending_results[$].last = 1'b1;
   endfunction

   // result checker
   always @(posedge clock) begin
      result_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result kind %0d key %h value %h status %b last %b",
                     $realtime, rsp_kind, rsp_key_res, rsp_value_res, rsp_status, rsp_last);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_kind !== e.kind || rsp_key_res !== e.key || rsp_value_res !== e.value ||
                rsp_status !== e.status || rsp_last !== e.last) begin
               $display("%0t: mismatch exp kind %0d key %h value %h status %b last %b",
                        $realtime, e.kind, e.key, e.value, e.status, e.last);
               $display("%0t:          got kind %0d key %h value %h status %b last %b",
                        $realtime, rsp_kind, rsp_key_res, rsp_value_res, rsp_status,
                        rsp_last);
               errors++;
            end
         end
      end
   end

   // receiver: random ready pattern, redrawn periodically, long hold-off on request
   always @(negedge clock) begin
      int hold_cnt = 0;
      int mode = 0;
      if (hold_req != 0) begin
         hold_cnt = 300;
         hold_req = 0;
      end
      if (cycles % 64 == 0) mode = $urandom_range(0, 2);
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_ready <= 1'b0;
      end else case (mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT_CYCLES) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_item(op_type op, logic [31:0] key, logic [63:0] value, logic found);
      if (burst_left == 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end else begin
         @(negedge clock);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_op <= op;
      req_key <= key;
      req_value <= value;
      req_found <= found;
      do @(posedge clock); while (!req_ready);
      predict_item(op, key, value, found);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_capacity(logic [CAP_BITS-1:0] c);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_capacity <= c;
      do @(posedge clock); while (!csr_ready);
      capacity = c;
      empty_cache();
      missed_keys.delete();
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_items(int count);
      logic [31:0] k;
      int pick;
      for (int n = 0; n < count; n++) begin
         k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 23)] : $urandom;
         pick = $urandom_range(0, 99);
         if (pick < 40)
            send_item(OP_SET, k, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
         else if (pick < 70)
            send_item(OP_GET, k, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
         else if (pick < 93) begin
            if (missed_keys.size() != 0 && $urandom_range(0, 3) != 0) k = missed_keys.pop_front();
            send_item(OP_FILL, k, {$urandom, $urandom}, $urandom_range(0, 4) != 0);
         end else
            send_item(OP_FLUSH, k, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_basic_ops();
      send_item(OP_SET, 32'h0, 64'h0, 1'b1);
      send_item(OP_SET, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0);
      send_item(OP_GET, 32'hffff_ffff, '0, 1'b1);
      send_item(OP_GET, 32'h1234_5678, '0, 1'b0);
      send_item(OP_FILL, 32'h1234_5678, 64'hdead_beef_0bad_f00d, 1'b1);
      send_item(OP_FILL, 32'h5555_aaaa, 64'h1, 1'b0);
      send_item(OP_FILL, 32'h0, 64'haaaa_5555_aaaa_5555, 1'b1);  // fill on a cached key
      send_item(OP_GET, 32'h0, '0, 1'b0);
      send_item(OP_FLUSH, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b1);
      send_item(OP_FLUSH, 32'h0, '0, 1'b0);
   endtask

   task automatic test_eviction();
      write_capacity(5'd2);
      send_item(OP_SET, 32'h10, 64'h100, 1'b0);
      send_item(OP_FILL, 32'h11, 64'h110, 1'b1);
      send_item(OP_SET, 32'h12, 64'h120, 1'b0);   // evicts a dirty entry
      send_item(OP_SET, 32'h13, 64'h130, 1'b0);   // evicts a clean one
      send_item(OP_FLUSH, '0, '0, 1'b0);
   endtask

   task automatic test_bypass();
      write_capacity(5'd0);
      send_item(OP_SET, 32'h20, 64'h200, 1'b0);
      send_item(OP_GET, 32'h20, '0, 1'b0);
      send_item(OP_FILL, 32'h20, 64'h201, 1'b1);
      send_item(OP_FLUSH, '0, '0, 1'b0);
      write_capacity(5'd31);                      // saturates at the depth
      send_item(OP_SET, 32'h30, 64'h300, 1'b0);
      send_item(OP_GET, 32'h30, '0, 1'b0);
   endtask

   task automatic test_random();
      int caps[6] = '{16, 1, 3, 0, 31, 7};
      foreach (caps[i]) begin
         write_capacity(CAP_BITS'(caps[i]));
         foreach (key_pool[j]) key_pool[j] = (j < 4) ? $urandom : $urandom_range(0, 40);
         random_items(60);
      end
   endtask

   task automatic test_backpressure();
      write_capacity(5'd4);
      wait_drained();
      hold_req = 1;
      random_items(30);
      wait_drained();                             // sender pauses until all results are in
      random_items(20);
   endtask

   initial begin
      capacity = CAP_RESET;
      empty_cache();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_eviction();
      test_bypass();
      test_random();
      test_backpressure();
      wait_drained();
      repeat (30) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/fwkv_pkg.sv
rtl/core/fwkv_ram.sv
rtl/core/fwkv_front.sv
rtl/core/fwkv_back.sv
rtl/core/fifo_writeback_kv_cache.sv
tb/sv/tb_top.sv
